>>> hw/rtl/sv39m_pkg.sv
// Shared types and constants for the Sv39 page table mapper.
// No dependencies.
package sv39m_pkg;
  localparam int TABLE_PAGES_DEF = 64;
  localparam int IDX_W = 9;
  localparam int PPN_W = 44;
  localparam logic [43:0] POOL_BASE_RST = 44'd524288;
  localparam logic [26:0] DONE_MAX = 27'd67108864;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_VA = 3'd1, ST_SIZE = 3'd2, ST_MAPPED = 3'd3,
    ST_NOMEM = 3'd4, ST_NOTMAP = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_PAGE, S_RD, S_EVAL, S_CLR, S_LEAF_RD, S_LEAF_EVAL, S_DONE
  } state_t;
endpackage

>>> hw/rtl/sv39m_ram.sv
// Generic single-port RAM, registered read.
// No dependencies.
module sv39m_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> hw/rtl/sv39_page_table_mapper_top.sv
// Sv39 page table mapper top level.
// Uses sv39m_pkg and sv39m_ram.
//
// Usage: pulse start with in_* while busy is low. One result per
// transaction comes back with out_valid high for one cycle; the receiver
// cannot stall it. kind 0 maps every 4 KiB page of the range, allocating
// cleared tables from a bump counter; kind 1 looks up one va.
// Walk: each page passes a setup state, then a read and an evaluate state
// per level (3 levels), the leaf write done in the last evaluate.
// Each new table adds a clear of all its 512 entries. Every result shows
// out_valid in S_DONE, and busy drops in the cycle after.
// Size zero and a lookup above the va limit go from idle straight to S_DONE.
// Time is set by the single table RAM port.
// After reset the root page is cleared with busy high;
// cfg writes are taken at any time (cfg_ready is always high).
module sv39_page_table_mapper_top #(
  parameter int TABLE_PAGES = sv39m_pkg::TABLE_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [38:0] in_virt_addr,
  input  logic [55:0] in_phys_addr,
  input  logic [38:0] in_range_bytes,
  input  logic [7:0]  in_perm_bits,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [63:0] out_leaf_entry,
  output logic [26:0] out_pages_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [43:0] cfg_pool_base_page
);
  localparam int PG_W = $clog2(TABLE_PAGES);
  localparam int CNT_W = $clog2(TABLE_PAGES + 1);
  localparam int AW = PG_W + sv39m_pkg::IDX_W;

  sv39m_pkg::state_t st_r, st_nxt;
  logic [43:0] base_r;
  logic [CNT_W-1:0] free_r, free_nxt;
  logic [8:0] clr_r, clr_nxt;
  logic [1:0] lvl_r, lvl_nxt;
  logic [PG_W-1:0] page_r, page_nxt, newpg_r, newpg_nxt;
  logic kind_r;
  logic [26:0] cur_r, cur_nxt, last_r;
  logic [43:0] ppn_r, ppn_nxt;
  logic [7:0] perm_r;
  logic [26:0] done_r, done_nxt;
  logic [2:0] stat_r, stat_nxt;
  logic [63:0] leaf_r, leaf_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [39:0] endva;

  logic we;
  logic [AW-1:0] addr;
  logic [63:0] wdata, rdata;

  sv39m_ram #(.WIDTH(64), .DEPTH(TABLE_PAGES * 512)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign cfg_ready = 1'b1;
  assign busy = (st_r != sv39m_pkg::S_IDLE);
  assign endva = {1'b0, in_virt_addr} + {1'b0, in_range_bytes} - 40'd1;

  logic [8:0] vidx;
  logic [43:0] eidx;
  always_comb begin
    unique case (lvl_r)
      2'd2: vidx = cur_r[26:18];
      2'd1: vidx = cur_r[17:9];
      default: vidx = cur_r[8:0];
    endcase
  end
  assign eidx = rdata[53:10] - base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sv39m_pkg::S_INIT;
      free_r <= CNT_W'(1);
      clr_r <= '0;
      base_r <= sv39m_pkg::POOL_BASE_RST;
    end else begin
      st_r <= st_nxt;
      free_r <= free_nxt;
      clr_r <= clr_nxt;
      if (cfg_valid) base_r <= cfg_pool_base_page;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r <= lvl_nxt; page_r <= page_nxt; newpg_r <= newpg_nxt;
    cur_r <= cur_nxt; ppn_r <= ppn_nxt; done_r <= done_nxt;
    stat_r <= stat_nxt; leaf_r <= leaf_nxt; slot_r <= slot_nxt;
    if (start && !busy) begin
      kind_r <= in_kind;
      last_r <= endva[38:12];
      perm_r <= in_perm_bits;
    end
  end

  always_comb begin
    st_nxt = st_r; free_nxt = free_r; clr_nxt = clr_r; lvl_nxt = lvl_r;
    page_nxt = page_r; newpg_nxt = newpg_r; cur_nxt = cur_r; ppn_nxt = ppn_r;
    done_nxt = done_r; stat_nxt = stat_r; leaf_nxt = leaf_r; slot_nxt = slot_r;
    we = 1'b0; addr = {page_r, vidx}; wdata = '0;
    out_valid = 1'b0;
    unique case (st_r)
      sv39m_pkg::S_INIT: begin
        we = 1'b1; addr = {PG_W'(0), clr_r};
        clr_nxt = clr_r + 9'd1;
        if (clr_r == 9'd511) st_nxt = sv39m_pkg::S_IDLE;
      end
      sv39m_pkg::S_IDLE: begin
        if (start) begin
          cur_nxt = in_virt_addr[38:12];
          ppn_nxt = in_phys_addr[55:12];
          done_nxt = '0; leaf_nxt = '0; stat_nxt = sv39m_pkg::ST_OK;
          if (in_kind) begin
            if (in_virt_addr[38]) begin
              stat_nxt = sv39m_pkg::ST_VA; st_nxt = sv39m_pkg::S_DONE;
            end else st_nxt = sv39m_pkg::S_PAGE;
          end else if (in_range_bytes == '0) begin
            stat_nxt = sv39m_pkg::ST_SIZE; st_nxt = sv39m_pkg::S_DONE;
          end else st_nxt = sv39m_pkg::S_PAGE;
        end
      end
      sv39m_pkg::S_PAGE: begin
        lvl_nxt = 2'd2; page_nxt = '0;
        if (cur_r[26]) begin
          stat_nxt = sv39m_pkg::ST_VA; st_nxt = sv39m_pkg::S_DONE;
        end else st_nxt = sv39m_pkg::S_RD;
      end
      sv39m_pkg::S_RD: st_nxt = sv39m_pkg::S_EVAL;
      sv39m_pkg::S_EVAL: begin
        if (rdata[0]) begin
          if (eidx >= 44'(free_r)) begin
            stat_nxt = kind_r ? sv39m_pkg::ST_NOTMAP : sv39m_pkg::ST_NOMEM;
            st_nxt = sv39m_pkg::S_DONE;
          end else begin
            page_nxt = eidx[PG_W-1:0];
            lvl_nxt = lvl_r - 2'd1;
            st_nxt = (lvl_r == 2'd1) ? sv39m_pkg::S_LEAF_RD : sv39m_pkg::S_RD;
          end
        end else if (kind_r) begin
          stat_nxt = sv39m_pkg::ST_NOTMAP; st_nxt = sv39m_pkg::S_DONE;
        end else if (free_r >= CNT_W'(TABLE_PAGES)) begin
          stat_nxt = sv39m_pkg::ST_NOMEM; st_nxt = sv39m_pkg::S_DONE;
        end else begin
          // link new table, then clear it
          we = 1'b1;
          wdata = {10'd0, base_r + 44'(free_r), 9'd0, 1'b1};
          newpg_nxt = free_r[PG_W-1:0];
          free_nxt = free_r + CNT_W'(1);
          clr_nxt = '0;
          st_nxt = sv39m_pkg::S_CLR;
        end
      end
      sv39m_pkg::S_CLR: begin
        we = 1'b1; addr = {newpg_r, clr_r};
        clr_nxt = clr_r + 9'd1;
        if (clr_r == 9'd511) begin
          page_nxt = newpg_r;
          lvl_nxt = lvl_r - 2'd1;
          st_nxt = (lvl_r == 2'd1) ? sv39m_pkg::S_LEAF_RD : sv39m_pkg::S_RD;
        end
      end
      sv39m_pkg::S_LEAF_RD: begin
        slot_nxt = {page_r, vidx};
        st_nxt = sv39m_pkg::S_LEAF_EVAL;
      end
      sv39m_pkg::S_LEAF_EVAL: begin
        addr = slot_r;
        st_nxt = sv39m_pkg::S_DONE;
        if (kind_r) begin
          if (rdata[0]) leaf_nxt = rdata;
          else stat_nxt = sv39m_pkg::ST_NOTMAP;
        end else if (rdata[0]) begin
          stat_nxt = sv39m_pkg::ST_MAPPED;
        end else begin
          we = 1'b1;
          wdata = {10'd0, ppn_r, 2'b00, perm_r | 8'd1};
          if (done_r != sv39m_pkg::DONE_MAX) done_nxt = done_r + 27'd1;
          if (cur_r != last_r) begin
            cur_nxt = cur_r + 27'd1;
            ppn_nxt = ppn_r + 44'd1;
            st_nxt = sv39m_pkg::S_PAGE;
          end
        end
      end
      sv39m_pkg::S_DONE: begin
        out_valid = 1'b1;
        st_nxt = sv39m_pkg::S_IDLE;
      end
      default: st_nxt = sv39m_pkg::S_IDLE;
    endcase
  end

  assign out_status = stat_r;
  assign out_leaf_entry = leaf_r;
  assign out_pages_done = done_r;
endmodule

>>> hw/rtl/sv39m_checker.sv
// Port-level checks for the Sv39 page table mapper.
// Uses sv39m_pkg; bound to sv39_page_table_mapper_top.
module sv39m_props (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [63:0] out_leaf_entry,
  input logic [26:0] out_pages_done
);
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept without busy");
  a_res_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 3'(sv39m_pkg::ST_NOTMAP) &&
                  out_pages_done <= sv39m_pkg::DONE_MAX)
    else $error("bad status or page count");
  a_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != 3'(sv39m_pkg::ST_OK) |-> out_leaf_entry == '0)
    else $error("leaf on error");
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result longer than one cycle");
endmodule

bind sv39_page_table_mapper_top sv39m_props u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_leaf_entry(out_leaf_entry),
  .out_pages_done(out_pages_done)
);

>>> tb/sv39m_checker.sv
// Checker for the Sv39 page table mapper: watches the request, result and cfg channels,
// predicts every result with its own copy of the page table and compares.
// Depends on sv39m_pkg.
`timescale 1ns / 100ps

module sv39m_checker #(
  parameter int TABLE_PAGES = sv39m_pkg::TABLE_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_kind,
  input  logic [38:0] in_virt_addr,
  input  logic [55:0] in_phys_addr,
  input  logic [38:0] in_range_bytes,
  input  logic [7:0]  in_perm_bits,
  input  logic        out_valid,
  input  logic [2:0]  out_status,
  input  logic [63:0] out_leaf_entry,
  input  logic [26:0] out_pages_done,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [43:0] cfg_pool_base_page,
  output int          fail_count,
  output int          pending_results
);
  localparam int ENTRIES = 512;
  localparam logic        KIND_MAP = 1'b0;
  localparam logic [63:0] VA_TOP = 64'd1 << 38;
  localparam logic [63:0] PAGE_BYTES = 64'd4096;

  typedef struct {
    sv39m_pkg::status_t st;
    logic [63:0]        leaf;
    logic [26:0]        done;
  } walk_result_t;

  logic [63:0]  pt_mem [0:TABLE_PAGES*ENTRIES-1];
  int           free_page;
  logic [43:0]  pool_base;
  walk_result_t result_q[$];

  initial begin
    foreach (pt_mem[i]) pt_mem[i] = '0;
    free_page = 1;
    pool_base = sv39m_pkg::POOL_BASE_RST;
    fail_count = 0;
  end

  assign pending_results = result_q.size();

  // Walks to the level-0 slot of va, allocating cleared tables when asked.
  function automatic sv39m_pkg::status_t find_leaf_slot(input logic [63:0] va,
                                                        input bit alloc,
                                                        output int slot);
    int          page;
    int          at;
    logic [63:0] e;
    logic [43:0] idx;
    page = 0;
    slot = 0;
    for (int lvl = 2; lvl > 0; lvl--) begin
      at = page * ENTRIES + int'((va >> (12 + 9 * lvl)) & 64'h1ff);
      e = pt_mem[at];
      if (e[0]) begin
        idx = e[53:10] - pool_base;
        if (idx >= 44'(free_page))
          return alloc ? sv39m_pkg::ST_NOMEM : sv39m_pkg::ST_NOTMAP;
        page = int'(idx);
      end else begin
        if (!alloc) return sv39m_pkg::ST_NOTMAP;
        if (free_page >= TABLE_PAGES) return sv39m_pkg::ST_NOMEM;
        page = free_page;
        free_page++;
        for (int i = 0; i < ENTRIES; i++) pt_mem[page * ENTRIES + i] = '0;
        pt_mem[at] = {10'b0, pool_base + 44'(page), 9'b0, 1'b1};
      end
    end
    slot = page * ENTRIES + int'(va[20:12]);
    return sv39m_pkg::ST_OK;
  endfunction

  function automatic walk_result_t predict_request(input logic kind, input logic [38:0] va,
                                                   input logic [55:0] pa_in,
                                                   input logic [38:0] size,
                                                   input logic [7:0] perm);
    walk_result_t r;
    int           slot;
    logic [63:0]  cur, last;
    logic [55:0]  pa;
    r.st = sv39m_pkg::ST_OK;
    r.leaf = '0;
    r.done = '0;
    pa = pa_in;
    if (kind != KIND_MAP) begin
      if (64'(va) >= VA_TOP) begin
        r.st = sv39m_pkg::ST_VA;
      end else begin
        r.st = find_leaf_slot(64'(va), 1'b0, slot);
        if (r.st == sv39m_pkg::ST_OK) begin
          if (pt_mem[slot][0]) r.leaf = pt_mem[slot];
          else r.st = sv39m_pkg::ST_NOTMAP;
        end
      end
    end else if (size == '0) begin
      r.st = sv39m_pkg::ST_SIZE;
    end else begin
      cur = {25'b0, va[38:12], 12'b0};
      last = (64'(va) + 64'(size) - 64'd1) & ~(PAGE_BYTES - 64'd1);
      forever begin
        if (cur >= VA_TOP) begin
          r.st = sv39m_pkg::ST_VA;
          break;
        end
        r.st = find_leaf_slot(cur, 1'b1, slot);
        if (r.st != sv39m_pkg::ST_OK) break;
        if (pt_mem[slot][0]) begin
          r.st = sv39m_pkg::ST_MAPPED;
          break;
        end
        pt_mem[slot] = (64'(pa >> 12) << 10) | 64'(perm) | 64'd1;
        if (r.done < sv39m_pkg::DONE_MAX) r.done++;
        if (cur == last) break;
        cur += PAGE_BYTES;
        pa += 56'(PAGE_BYTES);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    walk_result_t exp_r;
    if (rst_n) begin
      // result of an earlier transaction is checked before a new one is predicted
      if (out_valid) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d leaf=%h done=%0d", $time,
                   out_status, out_leaf_entry, out_pages_done);
          fail_count++;
        end else begin
          exp_r = result_q.pop_front();
          if (out_status !== exp_r.st) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.st, out_status);
            fail_count++;
          end
          if (out_leaf_entry !== exp_r.leaf) begin
            $display("%0t: leaf_entry expected %h actual %h", $time, exp_r.leaf,
                     out_leaf_entry);
            fail_count++;
          end
          if (out_pages_done !== exp_r.done) begin
            $display("%0t: pages_done expected %0d actual %0d", $time, exp_r.done,
                     out_pages_done);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        result_q.push_back(predict_request(in_kind, in_virt_addr, in_phys_addr,
                                           in_range_bytes, in_perm_bits));
      if (cfg_valid && cfg_ready) pool_base = cfg_pool_base_page;
    end
  end
endmodule

>>> tb/testbench.sv
// Top of the Sv39 page table mapper testbench: clock, reset, request and cfg stimulus, verdict.
// Depends on sv39m_pkg, sv39_page_table_mapper_top and sv39m_checker.
`timescale 1ns / 100ps

module testbench;
  localparam logic        KIND_MAP = 1'b0;
  localparam logic        KIND_LOOKUP = 1'b1;
  localparam logic [38:0] MEG2 = 39'h20_0000;
  localparam logic [38:0] VA_TOP = 39'h40_0000_0000;
  localparam int          CYCLE_LIMIT = 4_000_000;

  logic        clk, rst_n, start, busy;
  logic        in_kind;
  logic [38:0] in_virt_addr;
  logic [55:0] in_phys_addr;
  logic [38:0] in_range_bytes;
  logic [7:0]  in_perm_bits;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [63:0] out_leaf_entry;
  logic [26:0] out_pages_done;
  logic        cfg_valid, cfg_ready;
  logic [43:0] cfg_pool_base_page;
  int          fail_count, pending_results, cycles;
  logic [38:0] hot_va [4];
  bit          burst;

  sv39_page_table_mapper_top uut (.*);
  sv39m_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_request(input logic kind, input logic [38:0] va, input logic [55:0] pa,
                              input logic [38:0] size, input logic [7:0] perm);
    int gap;
    gap = burst ? 0 : int'($urandom_range(0, 17));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_virt_addr <= va;
    in_phys_addr <= pa;
    in_range_bytes <= size;
    in_perm_bits <= perm;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain_results;
    start <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_pool_base(input logic [43:0] value);
    cfg_valid <= 1'b1;
    cfg_pool_base_page <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request;
    logic        kind;
    logic [38:0] va, size;
    int          pick;
    kind = $urandom_range(0, 1) ? KIND_LOOKUP : KIND_MAP;
    pick = $urandom_range(0, 99);
    if (pick < 4) va = 39'({$urandom, $urandom}) & (VA_TOP - 39'd1);  // fresh region
    else if (pick < 8) va = 39'({$urandom, $urandom});                // may be above the va limit
    else va = hot_va[$urandom_range(0, 3)] + 39'($urandom_range(0, 2 * 512 * 4096 - 1));
    pick = $urandom_range(0, 199);
    if (kind == KIND_LOOKUP) size = 39'({$urandom, $urandom});       // ignored by lookup
    else if (pick == 0) size = 39'($urandom_range(1, 1 << 20));
    else if (pick < 6) size = '0;
    else size = 39'($urandom_range(1, 8 * 4096));
    send_request(kind, va, 56'({$urandom, $urandom}), size, 8'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = KIND_MAP;
    in_virt_addr = '0;
    in_phys_addr = '0;
    in_range_bytes = '0;
    in_perm_bits = '0;
    cfg_valid = 1'b0;
    cfg_pool_base_page = '0;
    burst = 1'b0;
    foreach (hot_va[i]) hot_va[i] = 39'({$urandom, $urandom}) & (VA_TOP - 39'd4 * MEG2);
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    send_request(KIND_MAP, 39'd0, 56'd0, 39'd0, 8'h0f);                  // size zero
    send_request(KIND_MAP, 39'd0, 56'h12_3456_7000, 39'd1, 8'h00);
    send_request(KIND_LOOKUP, 39'd0, '1, '1, '1);
    send_request(KIND_MAP, 39'd0, 56'd0, 39'd1, 8'hff);                  // already mapped
    send_request(KIND_MAP, 39'd0, '1, 39'h40_0000_0000, 8'hff);          // max size, mapped
    send_request(KIND_LOOKUP, 39'h25_8000, '0, '0, '0);                  // no level-0 table
    send_request(KIND_LOOKUP, 39'h12_3456_7000, '0, '0, '0);             // no table
    send_request(KIND_LOOKUP, '1, '0, '0, '0);                           // above va limit
    send_request(KIND_MAP, VA_TOP - 39'd4096, '0, 39'd1, 8'h0e);
    send_request(KIND_MAP, VA_TOP, '0, 39'd1, 8'h0e);                    // above va limit
    send_request(KIND_MAP, VA_TOP - 39'd8192 + 39'd5, 56'hab_c000, 39'd3 * 39'd4096, 8'h3f);
    send_request(KIND_LOOKUP, VA_TOP - 39'd8000, '0, '0, '0);
    send_request(KIND_MAP, 39'h1000_0ff0, '1, 39'd8192, 8'hc7);          // pa wraps
    send_request(KIND_LOOKUP, 39'h1000_2abc, '0, '0, '0);
    send_request(KIND_MAP, 39'h5555_5555, 56'haa_aaaa_aaaa_aaaa, 39'h2aaa, 8'h55);
    send_request(KIND_LOOKUP, 39'h5555_7000, '0, '0, '0);
    drain_results();

    // random phases, each under its own pool base
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_pool_base('0);
        1: write_pool_base('1);
        2: write_pool_base(sv39m_pkg::POOL_BASE_RST);
        3: write_pool_base(44'h800_0000_0000);
        default: write_pool_base(44'({$urandom, $urandom}));
      endcase
      for (int n = 0; n < 300; n++) begin
        if ($urandom_range(0, 39) == 0) burst = !burst;
        random_request();
      end
      burst = 1'b0;
      drain_results();
    end

    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
